// ===== rtl/core/ssrq_pkg.sv =====
// Shared types and constants for the sorted sector request queue.
// No dependencies; every other file in this block imports it.
package ssrq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int SECTOR_BITS = 48;
	localparam int TAG_BITS    = 8;
	localparam int KIND_BITS   = 3;
	localparam int STAT_BITS   = 2;
	localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

	// Request kinds
	localparam logic [KIND_BITS-1:0] KIND_INSERT = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_POP    = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_REMOVE = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_FORMER = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_LATTER = 3'd4;

	// Response status codes
	localparam logic [STAT_BITS-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_BITS-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_BITS-1:0] STAT_FULL  = 2'd2;
	localparam logic [STAT_BITS-1:0] STAT_NOTAG = 2'd3;

	typedef struct packed {
		logic [KIND_BITS-1:0]   kind;
		logic [SECTOR_BITS-1:0] sector;
		logic [TAG_BITS-1:0]    request_tag;
	} in_word_t;

	typedef struct packed {
		logic [STAT_BITS-1:0]   status;
		logic [SECTOR_BITS-1:0] out_sector;
		logic [TAG_BITS-1:0]    out_tag;
	} out_word_t;

	// Row update performed by the datapath
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_POP,
		OP_DELETE
	} op_t;

	// Entry returned in the response
	typedef enum logic [1:0] {
		SEL_NONE,
		SEL_HEAD,
		SEL_PREV,
		SEL_NEXT
	} sel_t;

	// Controller to datapath
	typedef struct packed {
		logic                 load;
		logic                 emit;
		op_t                  op;
		sel_t                 sel;
		logic [STAT_BITS-1:0] status;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic found;
		logic at_first;
		logic at_last;
	} dp_stat_t;

endpackage

// ===== rtl/core/ssrq_ctrl.sv =====
// Controller for the sorted sector request queue: accepts a word, decodes it
// against the datapath flags and issues the row update. Depends on ssrq_pkg.
module ssrq_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ssrq_pkg::KIND_BITS-1:0] kind,
	input  ssrq_pkg::dp_stat_t             stat,
	output ssrq_pkg::ctl_cmd_t             cmd,
	output logic                           busy,
	output logic                           done
);
	import ssrq_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t               state_q;
	logic [KIND_BITS-1:0] kind_q;
	logic                 done_q;

	// Hold state, latched kind and the response strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= KIND_INSERT;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_EXEC);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q  <= kind;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q == S_EXEC);
	assign done = done_q;

	// Decode the latched kind against the row flags
	always_comb begin
		cmd        = '0;
		cmd.op     = OP_HOLD;
		cmd.sel    = SEL_NONE;
		cmd.status = STAT_OK;
		cmd.load   = start && (state_q == S_IDLE);
		cmd.emit   = (state_q == S_EXEC);
		if (state_q == S_EXEC) begin
			case (kind_q)
				KIND_INSERT: begin
					if (stat.full) cmd.status = STAT_FULL;
					else           cmd.op     = OP_INSERT;
				end
				KIND_POP: begin
					if (stat.empty) begin
						cmd.status = STAT_EMPTY;
					end else begin
						cmd.op  = OP_POP;
						cmd.sel = SEL_HEAD;
					end
				end
				KIND_REMOVE: begin
					if (!stat.found) cmd.status = STAT_NOTAG;
					else             cmd.op     = OP_DELETE;
				end
				KIND_FORMER: begin
					if (!stat.found)       cmd.status = STAT_NOTAG;
					else if (stat.at_first) cmd.status = STAT_EMPTY;
					else                   cmd.sel    = SEL_PREV;
				end
				KIND_LATTER: begin
					if (!stat.found)      cmd.status = STAT_NOTAG;
					else if (stat.at_last) cmd.status = STAT_EMPTY;
					else                  cmd.sel    = SEL_NEXT;
				end
				default: begin
					cmd.status = STAT_OK;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/ssrq_dp.sv =====
// Datapath for the sorted sector request queue: a shifting row of sorted
// entries, per-entry compare and tag match, and the response register.
// Depends on ssrq_pkg.
module ssrq_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  ssrq_pkg::in_word_t  req,
	input  ssrq_pkg::ctl_cmd_t  cmd,
	output ssrq_pkg::dp_stat_t  stat,
	output ssrq_pkg::out_word_t rsp
);
	import ssrq_pkg::*;

	logic [CNT_BITS-1:0]    cnt_q;
	logic [SECTOR_BITS-1:0] sec_q [QUEUE_DEPTH];
	logic [TAG_BITS-1:0]    tag_q [QUEUE_DEPTH];
	in_word_t               req_q;
	out_word_t              rsp_q;

	logic [QUEUE_DEPTH-1:0] valid;
	logic [QUEUE_DEPTH-1:0] last;
	logic [QUEUE_DEPTH-1:0] le;
	logic [QUEUE_DEPTH-1:0] match;
	logic [QUEUE_DEPTH-1:0] first;
	logic [QUEUE_DEPTH-1:0] del_mask;
	logic [QUEUE_DEPTH-1:0] pick;
	logic [SECTOR_BITS-1:0] pick_sec;
	logic [TAG_BITS-1:0]    pick_tag;

	// Per-entry valid, sector compare and tag match
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			valid[i] = (CNT_BITS'(i) < cnt_q);
			le[i]    = valid[i] && (sec_q[i] <= req_q.sector);
			match[i] = valid[i] && (tag_q[i] == req_q.request_tag);
		end
		last  = valid & ~(valid >> 1);
		first = match & (~match + QUEUE_DEPTH'(1));
	end

	assign stat.empty    = (cnt_q == '0);
	assign stat.full     = (cnt_q == CNT_BITS'(QUEUE_DEPTH));
	assign stat.found    = |match;
	assign stat.at_first = first[0];
	assign stat.at_last  = |(first & last);

	// Entries at and above the matched one shift down on delete; all on pop
	assign del_mask = (cmd.op == OP_POP) ? '1 : ~(first - QUEUE_DEPTH'(1));

	// Select the entry to report
	always_comb begin
		case (cmd.sel)
			SEL_HEAD: pick = QUEUE_DEPTH'(1);
			SEL_PREV: pick = first >> 1;
			SEL_NEXT: pick = first << 1;
			default:  pick = '0;
		endcase
		pick_sec = '0;
		pick_tag = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			pick_sec = pick_sec | ({SECTOR_BITS{pick[i]}} & sec_q[i]);
			pick_tag = pick_tag | ({TAG_BITS{pick[i]}} & tag_q[i]);
		end
	end

	// Hold the entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.emit) begin
			case (cmd.op)
				OP_INSERT:          cnt_q <= cnt_q + CNT_BITS'(1);
				OP_POP, OP_DELETE:  cnt_q <= cnt_q - CNT_BITS'(1);
				default:            cnt_q <= cnt_q;
			endcase
		end
	end

	// Capture the request word and the response word
	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.emit) begin
			rsp_q.status     <= cmd.status;
			rsp_q.out_sector <= pick_sec;
			rsp_q.out_tag    <= pick_tag;
		end
	end

	// Shift the sorted row: open a slot on insert, close one on pop or delete
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				case (cmd.op)
					OP_INSERT: begin
						if (!le[i]) begin
							if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
								sec_q[i] <= req_q.sector;
								tag_q[i] <= req_q.request_tag;
							end else begin
								sec_q[i] <= sec_q[(i == 0) ? 0 : i - 1];
								tag_q[i] <= tag_q[(i == 0) ? 0 : i - 1];
							end
						end
					end
					OP_POP, OP_DELETE: begin
						if (del_mask[i] && i < QUEUE_DEPTH - 1) begin
							sec_q[i] <= sec_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
							tag_q[i] <= tag_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
						end
					end
					default: begin
						sec_q[i] <= sec_q[i];
					end
				endcase
			end
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== rtl/core/sorted_sector_request_queue.sv =====
// Top level of the sorted sector request queue: controller plus entry row.
// Depends on ssrq_pkg, ssrq_ctrl and ssrq_dp.
//
// channel   ports             direction  transfer
// request   start, busy, req  in         start high and busy low at a clock edge
// response  done, rsp         out        done high for one cycle, always taken
//
// Each word is handled in order: the request is latched, then in the EXEC
// state the compare and tag match across all entries and the row shift are done.
// busy is high while the word is in EXEC; the response appears in the next
// cycle, when a new word may already be taken. Reset empties the queue;
// entry contents are not cleared. The receiver cannot stall the response.
module sorted_sector_request_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ssrq_pkg::in_word_t  req,
	output logic                done,
	output ssrq_pkg::out_word_t rsp
);
	import ssrq_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	// Sequence each word
	ssrq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (req.kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Hold and update the sorted entries
	ssrq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for sorted_sector_request_queue: a clocked driver feeds request words from a
// backlog, and a monitor checks each response against an in-bench model of the sorted row.
// Depends on ssrq_pkg and the RTL under rtl/core.
module testbench;
	import ssrq_pkg::*;

	localparam int STALL_LIMIT = 300;
	localparam int RANDOM_WORDS = 1280;
	localparam int CALM_TAIL = 150;

	typedef struct {
		in_word_t    w;
		int unsigned gap;
		bit          drain;
	} stim_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	in_word_t  req = '0;
	logic      done;
	out_word_t rsp;

	stim_t     req_backlog[$];
	out_word_t rsp_due[$];
	int        n_issued = 0;
	int        n_answered = 0;
	int        errs = 0;
	int        stall_cycles = 0;
	int        gap_left = 0;
	bit        took;
	stim_t     nxt;

	// model of the sorted entry row
	logic [SECTOR_BITS-1:0] row_sector[QUEUE_DEPTH];
	logic [TAG_BITS-1:0]    row_tag[QUEUE_DEPTH];
	int                     row_len = 0;

	sorted_sector_request_queue DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// close the hole at pos, shifting later entries down
	function automatic void drop_entry(int pos);
		int i;
		for (i = pos; i + 1 < row_len; i++) begin
			row_sector[i] = row_sector[i+1];
			row_tag[i] = row_tag[i+1];
		end
		row_len--;
	endfunction

	// apply one request word to the row model and return the response it yields
	function automatic out_word_t serve_request(in_word_t w);
		out_word_t r;
		int        pos;
		int        hit;
		int        i;
		r = '0;
		r.status = STAT_OK;
		hit = row_len;
		for (i = row_len - 1; i >= 0; i--)
			if (row_tag[i] == w.request_tag)
				hit = i;
		case (w.kind)
			KIND_INSERT: begin
				if (row_len >= QUEUE_DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					pos = row_len;
					while (pos > 0 && w.sector < row_sector[pos-1])
						pos--;
					for (i = row_len; i > pos; i--) begin
						row_sector[i] = row_sector[i-1];
						row_tag[i] = row_tag[i-1];
					end
					row_sector[pos] = w.sector;
					row_tag[pos] = w.request_tag;
					row_len++;
				end
			end
			KIND_POP: begin
				if (row_len == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.out_sector = row_sector[0];
					r.out_tag = row_tag[0];
					drop_entry(0);
				end
			end
			KIND_REMOVE: begin
				if (hit >= row_len)
					r.status = STAT_NOTAG;
				else
					drop_entry(hit);
			end
			KIND_FORMER: begin
				if (hit >= row_len) begin
					r.status = STAT_NOTAG;
				end else if (hit == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.out_sector = row_sector[hit-1];
					r.out_tag = row_tag[hit-1];
				end
			end
			KIND_LATTER: begin
				if (hit >= row_len) begin
					r.status = STAT_NOTAG;
				end else if (hit + 1 >= row_len) begin
					r.status = STAT_EMPTY;
				end else begin
					r.out_sector = row_sector[hit+1];
					r.out_tag = row_tag[hit+1];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [SECTOR_BITS-1:0] pick_sector();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return SECTOR_BITS'($urandom_range(0, 31));
			default: return SECTOR_BITS'({$urandom, $urandom});
		endcase
	endfunction

	function automatic logic [TAG_BITS-1:0] pick_tag();
		case ($urandom_range(0, 9))
			0, 1: return TAG_BITS'($urandom);
			2, 3: return TAG_BITS'($urandom_range(0, 23));
			default: return TAG_BITS'($urandom_range(0, 9));
		endcase
	endfunction

	task automatic queue_word(logic [KIND_BITS-1:0] kind, logic [SECTOR_BITS-1:0] sector,
			logic [TAG_BITS-1:0] tag, int unsigned gap, bit drain);
		stim_t s;
		s.w.kind = kind;
		s.w.sector = sector;
		s.w.request_tag = tag;
		s.gap = gap;
		s.drain = drain;
		req_backlog.push_back(s);
	endtask

	// driver: record accepted words, then present the next one or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			gap_left = 0;
		end else begin
			took = start && !busy;
			if (took) begin
				rsp_due.push_back(serve_request(req));
				n_issued <= n_issued + 1;
			end
			if (took || !start) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (req_backlog.size() != 0 && !(req_backlog[0].drain &&
						n_issued + int'(took) != n_answered)) begin
					nxt = req_backlog.pop_front();
					req <= nxt.w;
					start <= 1'b1;
					gap_left = nxt.gap;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: check each response word against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (rsp_due.size() == 0) begin
				errs++;
				if (errs <= 10)
					$display("unexpected response: status=%0d sector=%h tag=%h",
						rsp.status, rsp.out_sector, rsp.out_tag);
			end else begin
				out_word_t want;
				want = rsp_due.pop_front();
				n_answered <= n_answered + 1;
				if (rsp.status !== want.status || rsp.out_sector !== want.out_sector ||
						rsp.out_tag !== want.out_tag) begin
					errs++;
					if (errs <= 10)
						$display("mismatch at response %0d: status %0d/%0d sector %h/%h tag %h/%h",
							n_answered, want.status, rsp.status, want.out_sector,
							rsp.out_sector, want.out_tag, rsp.out_tag);
				end
			end
		end
	end

	// watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL sorted_sector_request_queue");
				$finish;
			end
		end
	end

	initial begin
		int                     i;
		int                     r;
		int                     ins;
		int                     pop;
		int unsigned            gap;
		logic [KIND_BITS-1:0]   kind;

		// directed: empty row, front insert, equal sectors, edges, unused kinds
		queue_word(KIND_POP, '1, 8'h00, 0, 1'b0);
		queue_word(KIND_REMOVE, '0, 8'h05, 0, 1'b0);
		queue_word(KIND_FORMER, '0, 8'h05, 3, 1'b0);
		queue_word(KIND_INSERT, '1, 8'hff, 0, 1'b0);
		queue_word(KIND_INSERT, '0, 8'h00, 0, 1'b0);
		queue_word(KIND_INSERT, '0, 8'h00, 1, 1'b0);
		queue_word(KIND_INSERT, 48'd100, 8'h07, 0, 1'b0);
		queue_word(KIND_FORMER, '1, 8'h00, 0, 1'b0);
		queue_word(KIND_LATTER, '0, 8'hff, 0, 1'b0);
		queue_word(KIND_LATTER, '0, 8'h00, 0, 1'b0);
		queue_word(KIND_FORMER, '0, 8'h07, 0, 1'b0);
		queue_word(KIND_REMOVE, '0, 8'h00, 0, 1'b0);
		queue_word(KIND_REMOVE, '0, 8'h09, 0, 1'b0);
		queue_word(KIND_LATTER, '0, 8'h09, 0, 1'b0);
		queue_word(3'd5, '1, 8'hff, 0, 1'b0);
		queue_word(3'd7, 48'h5a5a_a5a5_0f0f, 8'h3c, 0, 1'b0);
		queue_word(KIND_POP, '0, 8'h00, 0, 1'b0);
		queue_word(KIND_POP, '0, 8'h00, 0, 1'b0);
		queue_word(KIND_POP, '0, 8'h00, 0, 1'b0);
		queue_word(KIND_POP, '0, 8'h00, 0, 1'b1);

		// random: alternate fill, drain and balanced stretches
		for (i = 0; i < RANDOM_WORDS; i++) begin
			case ((i / 80) % 3)
				0: begin ins = 55; pop = 12; end
				1: begin ins = 15; pop = 40; end
				default: begin ins = 35; pop = 25; end
			endcase
			r = $urandom_range(0, 99);
			if (r < ins)
				kind = KIND_INSERT;
			else if (r < ins + pop)
				kind = KIND_POP;
			else if (r < 97)
				case ($urandom_range(0, 2))
					0: kind = KIND_REMOVE;
					1: kind = KIND_FORMER;
					default: kind = KIND_LATTER;
				endcase
			else
				kind = KIND_BITS'($urandom_range(5, 7));
			if (i >= RANDOM_WORDS - CALM_TAIL || (i / 60) % 4 == 3)
				gap = 0;
			else
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
			queue_word(kind, pick_sector(), pick_tag(), gap,
				i == 100 || i == 600 || i == 1000);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// hold until everything is sent and answered, then let the pipe settle
		while (req_backlog.size() != 0 || start || rsp_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		if (errs == 0 && rsp_due.size() == 0)
			$display("PASS sorted_sector_request_queue");
		else
			$display("FAIL sorted_sector_request_queue");
		$finish;
	end

endmodule
